FILE: design/vssp_pkg.sv
`timescale 1ns / 1ps

package vssp_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE_T,
    S_SCALE_P,
    S_UPD,
    S_SUM,
    S_START_AT,
    S_DIV_AT,
    S_DIV_AP,
    S_DONE
  } state_t;

  // Field widths
  localparam int ADC_W      = 10;
  localparam int TEMP_W     = 13;
  localparam int PULSE_W    = 7;
  localparam int THR_T_W    = 13;
  localparam int THR_P_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int HEALTH_W   = 3;
  localparam int RISK_W     = 2;
  localparam int QUAL_W     = 2;

  // Numerator widths of the two scaling divisions: 1023*5000+511 and 1023*70
  localparam int T_NUM_W = 23;
  localparam int P_NUM_W = 17;
  // Step counter of the divider
  localparam int CNT_W   = 5;

  // Largest averaged values
  localparam int TEMP_MAX  = 5000;
  localparam int PULSE_MAX = 120;

  // Scaling constants
  localparam logic [ADC_W-1:0]  ADC_FULL    = 10'd1023;
  localparam logic [12:0]       TEMP_SCALE  = 13'd5000;
  localparam logic [8:0]        TEMP_ROUND  = 9'd511;
  localparam logic [6:0]        PULSE_SCALE = 7'd70;
  localparam logic [PULSE_W-1:0] PULSE_BASE = 7'd50;

  // Sample limits
  localparam logic [ADC_W-1:0] NOFINGER_LIMIT    = 10'd12;
  localparam logic [ADC_W-1:0] PULSE_TOP_LIMIT   = 10'd1018;
  localparam logic [ADC_W-1:0] TEMP_BOTTOM_LIMIT = 10'd2;
  localparam logic [ADC_W-1:0] TEMP_TOP_LIMIT    = 10'd1020;
  localparam logic [PULSE_W-1:0] JUMP_LIMIT      = 7'd25;
  localparam logic [1:0]         HOLD_LOAD       = 2'd3;

  // Commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Health codes
  localparam logic [HEALTH_W-1:0] HEALTH_SENSOR_ERR = 3'd0;
  localparam logic [HEALTH_W-1:0] HEALTH_NO_FINGER  = 3'd1;
  localparam logic [HEALTH_W-1:0] HEALTH_NORMAL     = 3'd2;
  localparam logic [HEALTH_W-1:0] HEALTH_WARNING    = 3'd3;
  localparam logic [HEALTH_W-1:0] HEALTH_CRITICAL   = 3'd4;

  localparam logic [RISK_W-1:0] RISK_NONE = 2'd0;
  localparam logic [RISK_W-1:0] RISK_MAX  = 2'd3;

  // Quality grades
  localparam logic [QUAL_W-1:0] QUAL_BAD   = 2'd0;
  localparam logic [QUAL_W-1:0] QUAL_WEAK  = 2'd1;
  localparam logic [QUAL_W-1:0] QUAL_NOISY = 2'd2;
  localparam logic [QUAL_W-1:0] QUAL_GOOD  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW_WARN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH_WARN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW_CRIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH_CRIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW_WARN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH_WARN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LOW_CRIT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH_CRIT = 3'd7;

endpackage

FILE: design/vital_sign_sample_processor.sv
`timescale 1ns / 1ps

// Vital-sign sample processor.
// Input channel (in_valid/in_ready): one beat carries cmd, temp_sample and
// pulse_sample. cmd sample scales both readings, runs them through a moving
// average over the last WINDOW_DEPTH samples, grades pulse quality and
// classifies health with a risk score; cmd clear zeroes the min/max store.
// Output channel (out_valid/out_ready): one result beat per input beat, in
// order. The min/max fields show the store after that beat.
// Configuration channel (cfg_valid/cfg_ready, always ready): writes one of
// the eight alarm thresholds by index; write only while the block is idle.
// Sample beat sequence: S_SCALE_T and S_SCALE_P scale both readings through
// one shared divide-by-1023 fold, S_UPD writes the window, S_SUM sums it,
// S_START_AT starts the shared shift-subtract divider, S_DIV_AT and S_DIV_AP
// form the two averages, S_DONE hands the result over. A clear beat goes
// from S_IDLE straight to S_DONE. in_ready is high only when idle, so no new
// beat is taken before the last one has left S_DONE; the next beat is
// accepted while a result waits, and a stalled receiver holds the next
// finished result.
// Reset: thresholds return to their defaults, window fill, quality state
// and min/max store clear, both channels go idle.
module vital_sign_sample_processor #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vssp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vssp_pkg::CFG_DATA_W-1:0]       cfg_data,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic [vssp_pkg::ADC_W-1:0]            temp_sample,
  input  logic [vssp_pkg::ADC_W-1:0]            pulse_sample,
  // results
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [vssp_pkg::TEMP_W-1:0]           avg_temp,
  output logic [vssp_pkg::PULSE_W-1:0]          avg_pulse,
  output logic [vssp_pkg::HEALTH_W-1:0]         health,
  output logic [vssp_pkg::RISK_W-1:0]           risk,
  output logic [vssp_pkg::QUAL_W-1:0]           quality,
  output logic                                  extremes_valid,
  output logic [vssp_pkg::TEMP_W-1:0]           temp_min,
  output logic [vssp_pkg::TEMP_W-1:0]           temp_max,
  output logic [vssp_pkg::PULSE_W-1:0]          pulse_min,
  output logic [vssp_pkg::PULSE_W-1:0]          pulse_max
);
  import vssp_pkg::*;

  localparam int POS_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int TSUM_W = $clog2(WINDOW_DEPTH * TEMP_MAX + 1);
  localparam int PSUM_W = $clog2(WINDOW_DEPTH * PULSE_MAX + 1);
  localparam int DIV_W  = TSUM_W;
  localparam int DVS_W  = FILL_W;
  // left-align the pulse sum so that its division runs only over its own bits
  localparam int AP_SH  = DIV_W - PSUM_W;

  // ---------------------------------------------------------------------
  // Threshold registers
  // ---------------------------------------------------------------------
  logic [THR_T_W-1:0] temp_low_warn, temp_high_warn, temp_low_crit, temp_high_crit;
  logic [THR_P_W-1:0] pulse_low_warn, pulse_high_warn, pulse_low_crit, pulse_high_crit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_low_warn   <= 13'd360;
      temp_high_warn  <= 13'd380;
      temp_low_crit   <= 13'd350;
      temp_high_crit  <= 13'd390;
      pulse_low_warn  <= 8'd60;
      pulse_high_warn <= 8'd100;
      pulse_low_crit  <= 8'd45;
      pulse_high_crit <= 8'd120;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEMP_LOW_WARN:   temp_low_warn   <= cfg_data[THR_T_W-1:0];
        REG_TEMP_HIGH_WARN:  temp_high_warn  <= cfg_data[THR_T_W-1:0];
        REG_TEMP_LOW_CRIT:   temp_low_crit   <= cfg_data[THR_T_W-1:0];
        REG_TEMP_HIGH_CRIT:  temp_high_crit  <= cfg_data[THR_T_W-1:0];
        REG_PULSE_LOW_WARN:  pulse_low_warn  <= cfg_data[THR_P_W-1:0];
        REG_PULSE_HIGH_WARN: pulse_high_warn <= cfg_data[THR_P_W-1:0];
        REG_PULSE_LOW_CRIT:  pulse_low_crit  <= cfg_data[THR_P_W-1:0];
        REG_PULSE_HIGH_CRIT: pulse_high_crit <= cfg_data[THR_P_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // State and working registers
  // ---------------------------------------------------------------------
  state_t state, state_next;

  logic                cmd_reg;
  logic [ADC_W-1:0]    tadc, padc;
  logic [T_NUM_W-1:0]  num_reg;
  logic [TEMP_W-1:0]   t_now, avg_t;
  logic [PULSE_W-1:0]  p_now, avg_p;
  logic [QUAL_W-1:0]   quality_reg;
  logic [TSUM_W-1:0]   tsum;
  logic [PSUM_W-1:0]   psum;
  logic [POS_W-1:0]    sum_idx;

  // sample window: each entry is written once per pass, unread until written
  logic [TEMP_W-1:0]   temp_window  [WINDOW_DEPTH];
  logic [PULSE_W-1:0]  pulse_window [WINDOW_DEPTH];
  logic [POS_W-1:0]    window_pos;
  logic [FILL_W-1:0]   window_fill;

  // quality tracking
  logic [PULSE_W-1:0]  prev_raw_pulse;
  logic [1:0]          noise_hold;

  // min/max store
  logic                extremes_set;
  logic [TEMP_W-1:0]   min_temp_store, max_temp_store;
  logic [PULSE_W-1:0]  min_pulse_store, max_pulse_store;

  // ---------------------------------------------------------------------
  // Shared divider for the two window averages
  // ---------------------------------------------------------------------
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_dividend, div_quotient;
  logic [DVS_W-1:0]  div_divisor;
  logic [CNT_W-1:0]  div_nbits;

  vssp_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .nbits    (div_nbits),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // ---------------------------------------------------------------------
  // Scaling: round(adc*5000/1023) and adc*70/1023
  // ---------------------------------------------------------------------
  // x/1023 from x = 1024*hi + lo = 1023*hi + (hi + lo): fold the upper bits
  // back in twice, then one compare settles the last carry.
  function automatic logic [TEMP_W-1:0] div_by_1023(logic [T_NUM_W-1:0] x);
    logic [T_NUM_W-ADC_W-1:0] hi;
    logic [T_NUM_W-ADC_W:0]   s1;
    logic [ADC_W:0]           s2;
    logic [T_NUM_W-ADC_W:0]   q;
    hi = x[T_NUM_W-1:ADC_W];
    s1 = {1'b0, hi} + (T_NUM_W-ADC_W+1)'(x[ADC_W-1:0]);
    s2 = (ADC_W+1)'(s1[T_NUM_W-ADC_W:ADC_W]) + (ADC_W+1)'(s1[ADC_W-1:0]);
    q  = {1'b0, hi} + (T_NUM_W-ADC_W+1)'(s1[T_NUM_W-ADC_W:ADC_W])
         + (T_NUM_W-ADC_W+1)'(s2 >= (ADC_W+1)'(ADC_FULL));
    return q[TEMP_W-1:0];
  endfunction

  logic [T_NUM_W-1:0] t_num;
  logic [P_NUM_W-1:0] p_num;
  logic [TEMP_W-1:0]  scaled;

  assign t_num  = T_NUM_W'(temp_sample) * T_NUM_W'(TEMP_SCALE) + T_NUM_W'(TEMP_ROUND);
  assign p_num  = P_NUM_W'(padc) * P_NUM_W'(PULSE_SCALE);
  // one fold unit, fed with the temperature numerator first, then the pulse one
  assign scaled = div_by_1023(num_reg);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  logic [FILL_W-1:0] sum_cnt;
  logic              sum_last;
  logic              out_load;

  assign sum_cnt  = FILL_W'(sum_idx) + FILL_W'(1);
  assign sum_last = (sum_cnt == window_fill);
  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_nbits    = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (cmd == CMD_SAMPLE) begin
            state_next = S_SCALE_T;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCALE_T: begin
        state_next = S_SCALE_P;
      end
      S_SCALE_P: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        if (sum_last) begin
          state_next = S_START_AT;
        end
      end
      S_START_AT: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(tsum);
        div_divisor  = DVS_W'(window_fill);
        div_nbits    = CNT_W'(TSUM_W);
        state_next   = S_DIV_AT;
      end
      S_DIV_AT: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DIV_W'(psum) << AP_SH;
          div_divisor  = DVS_W'(window_fill);
          div_nbits    = CNT_W'(PSUM_W);
          state_next   = S_DIV_AP;
        end
      end
      S_DIV_AP: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Quality grading
  // ---------------------------------------------------------------------
  logic [PULSE_W-1:0] p_diff;
  logic [1:0]         hold_next;

  assign p_diff = (p_now > prev_raw_pulse) ? (p_now - prev_raw_pulse)
                                           : (prev_raw_pulse - p_now);

  always_comb begin
    if (p_diff > JUMP_LIMIT) begin
      hold_next = HOLD_LOAD;
    end else if (noise_hold != 2'd0) begin
      hold_next = noise_hold - 2'd1;
    end else begin
      hold_next = 2'd0;
    end
  end

  // ---------------------------------------------------------------------
  // Classification on the averaged values
  // ---------------------------------------------------------------------
  logic [THR_P_W-1:0]  avg_p_ext;
  logic                tc, tw, pc, pw, fever_tachy;
  logic [RISK_W-1:0]   risk_cnt;
  logic [HEALTH_W-1:0] health_c;
  logic [RISK_W-1:0]   risk_c;

  assign avg_p_ext   = THR_P_W'(avg_p);
  assign tc          = (avg_t >= temp_high_crit) || (avg_t <= temp_low_crit);
  assign tw          = !tc && ((avg_t >= temp_high_warn) || (avg_t < temp_low_warn));
  assign pc          = (avg_p_ext >= pulse_high_crit) || (avg_p_ext <= pulse_low_crit);
  assign pw          = !pc && ((avg_p_ext > pulse_high_warn) || (avg_p_ext < pulse_low_warn));
  assign fever_tachy = (avg_t >= temp_high_warn) && (avg_p_ext > pulse_high_warn);
  assign risk_cnt    = RISK_W'(tw || tc) + RISK_W'(pw || pc) + RISK_W'(fever_tachy);

  always_comb begin
    if ((tadc < TEMP_BOTTOM_LIMIT) || (tadc > TEMP_TOP_LIMIT)) begin
      health_c = HEALTH_SENSOR_ERR;
      risk_c   = RISK_MAX;
    end else if (padc < NOFINGER_LIMIT) begin
      health_c = HEALTH_NO_FINGER;
      risk_c   = RISK_NONE;
    end else if (tc || pc || (risk_cnt == RISK_MAX)) begin
      health_c = HEALTH_CRITICAL;
      risk_c   = RISK_MAX;
    end else if (risk_cnt != RISK_NONE) begin
      health_c = HEALTH_WARNING;
      risk_c   = risk_cnt;
    end else begin
      health_c = HEALTH_NORMAL;
      risk_c   = RISK_NONE;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  // capture the beat, scaled values, window entries, quality grade, sums and averages
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd_reg <= cmd;
        tadc    <= temp_sample;
        padc    <= pulse_sample;
        num_reg <= t_num;
      end
      S_SCALE_T: begin
        t_now   <= scaled;
        num_reg <= T_NUM_W'(p_num);
      end
      S_SCALE_P: begin
        p_now <= PULSE_BASE + scaled[PULSE_W-1:0];
      end
      S_UPD: begin
        temp_window[window_pos]  <= t_now;
        pulse_window[window_pos] <= p_now;
        tsum    <= '0;
        psum    <= '0;
        sum_idx <= '0;
        if (padc < NOFINGER_LIMIT) begin
          quality_reg <= QUAL_BAD;
        end else if (padc > PULSE_TOP_LIMIT) begin
          quality_reg <= QUAL_WEAK;
        end else begin
          quality_reg <= (hold_next != 2'd0) ? QUAL_NOISY : QUAL_GOOD;
        end
      end
      S_SUM: begin
        tsum    <= tsum + TSUM_W'(temp_window[sum_idx]);
        psum    <= psum + PSUM_W'(pulse_window[sum_idx]);
        sum_idx <= sum_idx + POS_W'(1);
      end
      S_DIV_AT: begin
        if (div_done) begin
          avg_t <= div_quotient[TEMP_W-1:0];
        end
      end
      S_DIV_AP: begin
        if (div_done) begin
          avg_p <= div_quotient[PULSE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // window position, fill count and quality history
  always_ff @(posedge clk) begin
    if (rst) begin
      window_pos     <= '0;
      window_fill    <= '0;
      prev_raw_pulse <= '0;
      noise_hold     <= '0;
    end else if (state == S_UPD) begin
      // advance the write slot, wrap at the window end
      if (window_pos == POS_W'(WINDOW_DEPTH - 1)) begin
        window_pos <= '0;
      end else begin
        window_pos <= window_pos + POS_W'(1);
      end
      if (window_fill != FILL_W'(WINDOW_DEPTH)) begin
        window_fill <= window_fill + FILL_W'(1);
      end
      // out-of-range pulse readings leave the history alone
      if ((padc >= NOFINGER_LIMIT) && (padc <= PULSE_TOP_LIMIT)) begin
        noise_hold     <= hold_next;
        prev_raw_pulse <= p_now;
      end
    end
  end

  // min/max store, updated as the result is handed to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      extremes_set    <= 1'b0;
      min_temp_store  <= '0;
      max_temp_store  <= '0;
      min_pulse_store <= '0;
      max_pulse_store <= '0;
    end else if (out_load) begin
      if (cmd_reg == CMD_CLEAR) begin
        extremes_set    <= 1'b0;
        min_temp_store  <= '0;
        max_temp_store  <= '0;
        min_pulse_store <= '0;
        max_pulse_store <= '0;
      end else if (health_c >= HEALTH_NORMAL) begin
        if (!extremes_set) begin
          // first valid reading loads all four
          extremes_set    <= 1'b1;
          min_temp_store  <= avg_t;
          max_temp_store  <= avg_t;
          min_pulse_store <= avg_p;
          max_pulse_store <= avg_p;
        end else begin
          if (avg_t < min_temp_store)  min_temp_store  <= avg_t;
          if (avg_t > max_temp_store)  max_temp_store  <= avg_t;
          if (avg_p < min_pulse_store) min_pulse_store <= avg_p;
          if (avg_p > max_pulse_store) max_pulse_store <= avg_p;
        end
      end
    end
  end

  // output register: hold the beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd_reg == CMD_CLEAR) begin
        avg_temp  <= '0;
        avg_pulse <= '0;
        health    <= HEALTH_SENSOR_ERR;
        risk      <= RISK_NONE;
        quality   <= QUAL_BAD;
      end else begin
        avg_temp  <= avg_t;
        avg_pulse <= avg_p;
        health    <= health_c;
        risk      <= risk_c;
        quality   <= quality_reg;
      end
    end
  end

  // the store changes only when the output register reloads
  assign extremes_valid = extremes_set;
  assign temp_min       = min_temp_store;
  assign temp_max       = max_temp_store;
  assign pulse_min      = min_pulse_store;
  assign pulse_max      = max_pulse_store;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    window_fill <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill count beyond window depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted while one is in work");

  a_clear_store: assert property (@(posedge clk) disable iff (rst)
    !extremes_set |-> (min_temp_store == '0 && max_temp_store == '0 &&
                       min_pulse_store == '0 && max_pulse_store == '0))
    else $error("min/max store not zero while empty");

  a_store_order: assert property (@(posedge clk) disable iff (rst)
    extremes_set |-> (min_temp_store <= max_temp_store &&
                      min_pulse_store <= max_pulse_store))
    else $error("min above max in the store");

  a_crit_risk: assert property (@(posedge clk) disable iff (rst)
    (out_valid && health == HEALTH_CRITICAL) |-> (risk == RISK_MAX))
    else $error("critical result without top risk");
`endif

endmodule

FILE: design/vssp_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend comes in
// left-aligned so that its top nbits bits hold the value; after nbits steps
// the quotient sits in quotient, upper bits zero.
module vssp_div #(
  parameter int DIVIDEND_W = 23,
  parameter int DIVISOR_W  = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [DIVIDEND_W-1:0]          dividend,
  input  logic [DIVISOR_W-1:0]           divisor,
  input  logic [vssp_pkg::CNT_W-1:0]     nbits,
  output logic                           done,
  output logic [DIVIDEND_W-1:0]          quotient
);
  import vssp_pkg::*;

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;

  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;
  logic                  qbit;
  logic [DIVISOR_W-1:0]  rem_next;

  assign rem_sh   = {rem, quo[DIVIDEND_W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign qbit     = (rem_sh >= {1'b0, dvs});
  assign rem_next = qbit ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nbits;
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], qbit};
      rem <= rem_next;
    end
  end

endmodule
